### rtl/sorted_task_table_assert.svh
// ----------------------------------------------------------------------------
// sorted task table assertion macros
// concurrent check shorthands used by the table rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_TASK_TABLE_ASSERT_SVH
`define SORTED_TASK_TABLE_ASSERT_SVH

// same-cycle implication under async reset
`define STT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under async reset
`define STT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// widths, codes and helpers for the sorted task table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 8;
    localparam int CMD_W     = 2;
    localparam int TASK_ID_W = 8;
    localparam int HOUR_W    = 5;
    localparam int STATUS_W  = 3;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ENTRY_W   = ID_BITS + HOUR_W;
    localparam int MATCH_W   = 16;

    localparam logic [HOUR_W-1:0] HOUR_LIMIT = HOUR_W'(24);

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDIT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HOUR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [HOUR_W-1:0]  hour;
    } entry_t;

    function automatic logic id_match(logic [ID_BITS-1:0] stored,
                                      logic [TASK_ID_W-1:0] wanted);
        return MATCH_W'(stored) == MATCH_W'(wanted);
    endfunction

    function automatic logic [TASK_ID_W-1:0] id_field(logic [ID_BITS-1:0] id);
        return TASK_ID_W'(id);
    endfunction

endpackage

`default_nettype wire

### rtl/stt_cmd_if.sv
// ----------------------------------------------------------------------------
// stt_cmd_if
// command channel of the sorted task table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stt_cmd_if import stt_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [TASK_ID_W-1:0] task_id;
    logic [HOUR_W-1:0]    hour;

    modport source (output valid, output command, output task_id, output hour,
                    input ready);
    modport sink   (input valid, input command, input task_id, input hour,
                    output ready);

endinterface

`default_nettype wire

### rtl/stt_rsp_if.sv
// ----------------------------------------------------------------------------
// stt_rsp_if
// result channel of the sorted task table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stt_rsp_if import stt_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [TASK_ID_W-1:0] entry_id;
    logic [HOUR_W-1:0]    entry_hour;
    logic                 last;

    modport source (output valid, output status, output entry_id,
                    output entry_hour, output last, input ready);
    modport sink   (input valid, input status, input entry_id,
                    input entry_hour, input last, output ready);

endinterface

`default_nettype wire

### rtl/sorted_task_table.sv
// per command, with results held while the receiver stalls:
// add moves entries back a slot from the end while their hour >= the new hour, then writes it
// remove searches slots in order for the id and moves later entries up; edit also re-adds it
// list gives each entry in order; errors and an id not found give a single cleared result
// one item at a time: ready again the cycle after the last result is loaded
// asynchronous active-low reset empties the table and clears the id counter
// ----------------------------------------------------------------------------
// sorted_task_table
// task entries kept in ascending hour order, walked by a small sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_task_table_assert.svh"

module sorted_task_table import stt_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    stt_cmd_if.sink   req,
    stt_rsp_if.source rsp
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] S_EMIT    = 4'd1;
    localparam logic [ST_W-1:0] S_FND_RD  = 4'd2;
    localparam logic [ST_W-1:0] S_FND_USE = 4'd3;
    localparam logic [ST_W-1:0] S_SHL_RD  = 4'd4;
    localparam logic [ST_W-1:0] S_SHL_USE = 4'd5;
    localparam logic [ST_W-1:0] S_RM_DONE = 4'd6;
    localparam logic [ST_W-1:0] S_INS_RD  = 4'd7;
    localparam logic [ST_W-1:0] S_INS_USE = 4'd8;
    localparam logic [ST_W-1:0] S_INS_WR  = 4'd9;
    localparam logic [ST_W-1:0] S_LST_RD  = 4'd10;
    localparam logic [ST_W-1:0] S_LST_USE = 4'd11;

    logic [ST_W-1:0]      state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ID_BITS-1:0]   nid_reg, nid_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [TASK_ID_W-1:0] tid_reg, tid_next;
    logic [HOUR_W-1:0]    hour_reg, hour_next;
    logic [ID_BITS-1:0]   eid_reg, eid_next;
    logic [HOUR_W-1:0]    ehour_reg, ehour_next;
    logic [STATUS_W-1:0]  res_st_reg, res_st_next;
    logic [ID_BITS-1:0]   res_id_reg, res_id_next;
    logic [HOUR_W-1:0]    res_hour_reg, res_hour_next;

    logic                 ov_reg, ov_next;
    logic [STATUS_W-1:0]  ost_reg, ost_next;
    logic [TASK_ID_W-1:0] oid_reg, oid_next;
    logic [HOUR_W-1:0]    ohour_reg, ohour_next;
    logic                 olast_reg, olast_next;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
    entry_t               rd_entry, new_entry;
    logic [CNT_W-1:0]     idx_inc, idx_inc2, idx_dec;
    logic                 out_free;

    stt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry       = entry_t'(ram_rdata);
    assign new_entry.id   = eid_reg;
    assign new_entry.hour = hour_reg;
    assign idx_inc        = idx_reg + CNT_W'(1);
    assign idx_inc2       = idx_reg + CNT_W'(2);
    assign idx_dec        = idx_reg - CNT_W'(1);
    assign out_free       = !ov_reg || rsp.ready;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ov_reg;
    assign rsp.status     = ost_reg;
    assign rsp.entry_id   = oid_reg;
    assign rsp.entry_hour = ohour_reg;
    assign rsp.last       = olast_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        nid_next      = nid_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        tid_next      = tid_reg;
        hour_next     = hour_reg;
        eid_next      = eid_reg;
        ehour_next    = ehour_reg;
        res_st_next   = res_st_reg;
        res_id_next   = res_id_reg;
        res_hour_next = res_hour_reg;
        ov_next       = ov_reg && !rsp.ready;
        ost_next      = ost_reg;
        oid_next      = oid_reg;
        ohour_next    = ohour_reg;
        olast_next    = olast_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = idx_reg[ADDR_W-1:0];
        ram_raddr     = idx_reg[ADDR_W-1:0];
        ram_wdata     = ram_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = req.command;
                    tid_next      = req.task_id;
                    hour_next     = req.hour;
                    idx_next      = '0;
                    res_id_next   = '0;
                    res_hour_next = '0;
                    unique case (req.command) inside
                        CMD_ADD:
                        begin
                            if (req.hour == '0 || req.hour >= HOUR_LIMIT)
                            begin
                                res_st_next = ST_BAD_HOUR;
                                state_next  = S_EMIT;
                            end
                            else if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                res_st_next = ST_FULL;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                eid_next   = nid_reg;
                                nid_next   = nid_reg + ID_BITS'(1);
                                idx_next   = cnt_reg;
                                state_next = (cnt_reg == '0) ? S_INS_WR : S_INS_RD;
                            end
                        end
                        CMD_EDIT, CMD_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_FND_RD;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_LST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_st_reg;
                    oid_next   = id_field(res_id_reg);
                    ohour_next = res_hour_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FND_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_FND_USE;
            end
            S_FND_USE:
            begin
                if (id_match(rd_entry.id, tid_reg))
                begin
                    eid_next   = rd_entry.id;
                    ehour_next = rd_entry.hour;
                    state_next = (idx_inc < cnt_reg) ? S_SHL_RD : S_RM_DONE;
                end
                else if (idx_inc == cnt_reg)
                begin
                    res_st_next   = ST_NOT_FOUND;
                    res_id_next   = '0;
                    res_hour_next = '0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FND_RD;
                end
            end
            S_SHL_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_inc[ADDR_W-1:0];
                state_next = S_SHL_USE;
            end
            S_SHL_USE:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = (idx_inc2 < cnt_reg) ? S_SHL_RD : S_RM_DONE;
            end
            S_RM_DONE:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cmd_reg == CMD_REMOVE)
                begin
                    res_st_next   = ST_OK;
                    res_id_next   = eid_reg;
                    res_hour_next = ehour_reg;
                    state_next    = S_EMIT;
                end
                else
                begin
                    idx_next   = cnt_reg - CNT_W'(1);
                    state_next = (cnt_reg == CNT_W'(1)) ? S_INS_WR : S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_dec[ADDR_W-1:0];
                state_next = S_INS_USE;
            end
            S_INS_USE:
            begin
                if (rd_entry.hour >= hour_reg)
                begin
                    ram_we     = 1'b1;
                    idx_next   = idx_dec;
                    state_next = (idx_dec == '0) ? S_INS_WR : S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                ram_we        = 1'b1;
                ram_wdata     = new_entry;
                cnt_next      = cnt_reg + CNT_W'(1);
                res_st_next   = ST_OK;
                res_id_next   = eid_reg;
                res_hour_next = hour_reg;
                state_next    = S_EMIT;
            end
            S_LST_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_LST_USE;
            end
            S_LST_USE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_OK;
                    oid_next   = id_field(rd_entry.id);
                    ohour_next = rd_entry.hour;
                    olast_next = (idx_inc == cnt_reg);
                    idx_next   = idx_inc;
                    state_next = (idx_inc == cnt_reg) ? S_IDLE : S_LST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            nid_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nid_reg   <= nid_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cmd_reg      <= cmd_next;
        tid_reg      <= tid_next;
        hour_reg     <= hour_next;
        eid_reg      <= eid_next;
        ehour_reg    <= ehour_next;
        res_st_reg   <= res_st_next;
        res_id_reg   <= res_id_next;
        res_hour_reg <= res_hour_next;
        ost_reg      <= ost_next;
        oid_reg      <= oid_next;
        ohour_reg    <= ohour_next;
        olast_reg    <= olast_next;
    end

    `STT_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DEPTH),
        "entry count above table depth")
    `STT_ASSERT_NXT(a_cnt_hold, clk, rst_n,
        (state_reg != S_RM_DONE) && (state_reg != S_INS_WR), $stable(cnt_reg),
        "entry count changed outside remove or insert")
    `STT_ASSERT_NXT(a_nid_hold, clk, rst_n,
        !(req.valid && req.ready && req.command == CMD_ADD), $stable(nid_reg),
        "id counter moved without an add")
    `STT_ASSERT_IMP(a_err_last, clk, rst_n, rsp.valid && rsp.status != ST_OK,
        rsp.last && rsp.entry_id == '0 && rsp.entry_hour == '0,
        "error result not a single cleared item")

endmodule

`default_nettype wire

### rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
